>>> src/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the sorted ID pool.
// ----------------------------------------------------------------------------
package sip_pkg;

  // Field widths of the request and result
  localparam int OP_W  = 3;
  localparam int IN_W  = 11;   // signed ID fields on the request
  localparam int ID_W  = 10;   // non-negative ID, also the taken ID
  localparam int MAX_IDS = 1 << ID_W;

  // Fixed-point shift used for division by the word size
  localparam int QSHIFT = 20;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_TAKE   = 3'd2;
  localparam logic [OP_W-1:0] OP_RANGE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture request
    logic decode;      // register word indices, set scan pointer
    logic idx_inc;     // step word pointer
    logic wr_en;       // write modified word back
    logic clear_all;   // drop every member
    logic respond;     // issue a result
    logic resp_take;   // result carries the taken ID
    logic resp_empty;  // result flags an empty set
  } sip_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic single_ok;   // single ID lies inside the pool
    logic range_ok;    // clamped range is not empty
    logic flag_hit;    // word under pointer holds a member
    logic idx_last;    // pointer at last word
    logic idx_at_hi;   // pointer at last word of range
  } sip_stat_t;

endpackage

>>> src/sorted_id_pool.sv
// ----------------------------------------------------------------------------
// sorted_id_pool
// Set of IDs held as a presence bitmap with one occupancy flag per word:
// add, remove, take smallest, add inclusive range, clear.
//
//   Channel   Ports                                     Handshake
//   request   in_op, in_first_id, in_last_id            start high, busy low
//   result    out_taken_id, out_was_empty               out_valid, one cycle
//
// Take scans the occupancy flags one word per cycle; add range reads and
// writes back each word it covers through the single-port word memory.
// The bitmap holds ceil(min(ID_COUNT,1024)/WORD_BITS) words, 16 at defaults.
// Result strobes in the first cycle with busy low; a new request may start then.
// Reset empties the set at once by clearing the occupancy flags.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module sorted_id_pool
  import sip_pkg::*;
#(
  parameter int ID_COUNT  = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        in_op,
  input  logic signed [IN_W-1:0] in_first_id,
  input  logic signed [IN_W-1:0] in_last_id,
  output logic                   out_valid,
  output logic [ID_W-1:0]        out_taken_id,
  output logic                   out_was_empty
);

  sip_cmd_t  cmd;
  sip_stat_t stat;

  // Sequencer
  sip_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Bitmap datapath
  sip_dp #(
    .ID_COUNT  (ID_COUNT),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_first_id   (in_first_id),
    .in_last_id    (in_last_id),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_taken_id  (out_taken_id),
    .out_was_empty (out_was_empty)
  );

endmodule

>>> src/sip_ctrl.sv
// ----------------------------------------------------------------------------
// sip_ctrl
// Sequencer for the sorted ID pool: decodes a request and steps the
// datapath through scan and read-modify-write of bitmap words.
// ----------------------------------------------------------------------------
module sip_ctrl
  import sip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sip_stat_t stat,
  output sip_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_RD     = 3'd3;
  localparam logic [2:0] ST_MOD    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        case (stat.op)
          OP_ADD, OP_REMOVE: begin
            if (stat.single_ok) begin
              state_nxt = ST_RD;
            end else begin
              cmd.respond = 1'b1;
              state_nxt   = ST_IDLE;
            end
          end
          OP_RANGE: begin
            if (stat.range_ok) begin
              state_nxt = ST_RD;
            end else begin
              cmd.respond = 1'b1;
              state_nxt   = ST_IDLE;
            end
          end
          OP_TAKE: begin
            state_nxt = ST_SCAN;
          end
          OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            cmd.respond   = 1'b1;
            state_nxt     = ST_IDLE;
          end
          default: begin
            cmd.respond = 1'b1;
            state_nxt   = ST_IDLE;
          end
        endcase
      end
      // walk the occupancy flags for the first non-empty word
      ST_SCAN: begin
        if (stat.flag_hit) begin
          state_nxt = ST_MOD;
        end else if (stat.idx_last) begin
          cmd.respond    = 1'b1;
          cmd.resp_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_RD: begin
        state_nxt = ST_MOD;
      end
      // write back; a range moves on to its next word
      ST_MOD: begin
        cmd.wr_en = 1'b1;
        if (stat.op == OP_RANGE && !stat.idx_at_hi) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_RD;
        end else begin
          cmd.respond   = 1'b1;
          cmd.resp_take = (stat.op == OP_TAKE);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/sip_dp.sv
// ----------------------------------------------------------------------------
// sip_dp
// Datapath of the sorted ID pool: request registers, word index decode,
// bitmap word memory with occupancy flags, word update and result register.
// ----------------------------------------------------------------------------
module sip_dp
  import sip_pkg::*;
#(
  parameter int ID_COUNT  = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [OP_W-1:0]        in_op,
  input  logic signed [IN_W-1:0] in_first_id,
  input  logic signed [IN_W-1:0] in_last_id,
  input  sip_cmd_t               cmd,
  output sip_stat_t              stat,
  output logic                   out_valid,
  output logic [ID_W-1:0]        out_taken_id,
  output logic                   out_was_empty
);

  // IDs past the request's reach or the pool size are never stored
  localparam int LIM_I = (ID_COUNT < MAX_IDS) ? ID_COUNT : MAX_IDS;
  localparam int WORDS = (LIM_I + WORD_BITS - 1) / WORD_BITS;
  localparam int WI_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BI_W  = $clog2(WORD_BITS);
  localparam int RECIP = ((1 << QSHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW    = ID_W + QSHIFT;
  localparam logic [ID_W-1:0] LAST_MAX = ID_W'(LIM_I - 1);
  localparam logic [BI_W-1:0] TOP_BIT  = BI_W'(WORD_BITS - 1);

  // Request registers
  logic [OP_W-1:0] op_r;
  logic [IN_W-1:0] first_r;
  logic [IN_W-1:0] last_r;

  // Word pointer and decoded bounds
  logic [WI_W-1:0] idx_r;
  logic [WI_W-1:0] wlo_r;
  logic [WI_W-1:0] whi_r;

  // Bitmap store
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     nonempty_r;
  logic [WORD_BITS-1:0] rd_r;
  logic                 rdv_r;

  // Result registers
  logic            out_valid_r;
  logic [ID_W-1:0] taken_r;
  logic            empty_r;

  logic [ID_W-1:0]      first_c;
  logic [ID_W-1:0]      last_c;
  logic [PW-1:0]        prod_lo;
  logic [PW-1:0]        prod_hi;
  logic [WI_W-1:0]      q_lo;
  logic [WI_W-1:0]      q_hi;
  logic [BI_W-1:0]      lo_b;
  logic [BI_W-1:0]      hi_b;
  logic [WORD_BITS-1:0] rd_eff;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] rng_mask;
  logic [WORD_BITS-1:0] word_nxt;
  logic [BI_W-1:0]      ffs_pos;
  logic [ID_W-1:0]      taken_nxt;

  // Clamp bounds: negative first to zero, last to the top ID
  assign first_c = first_r[IN_W-1] ? '0 : first_r[ID_W-1:0];
  assign last_c  = (last_r[ID_W-1:0] > LAST_MAX) ? LAST_MAX : last_r[ID_W-1:0];

  // Word index by reciprocal multiply, exact for 10-bit IDs
  assign prod_lo = PW'(first_c) * PW'(RECIP);
  assign prod_hi = PW'(last_c) * PW'(RECIP);
  assign q_lo    = WI_W'(prod_lo >> QSHIFT);
  assign q_hi    = WI_W'(prod_hi >> QSHIFT);

  // Bit offsets within the first and last words
  assign lo_b = BI_W'(first_c - ID_W'(wlo_r * WORD_BITS));
  assign hi_b = BI_W'(last_c - ID_W'(whi_r * WORD_BITS));

  // Status
  assign stat.op        = op_r;
  assign stat.single_ok = !first_r[IN_W-1] && (first_r[ID_W-1:0] <= LAST_MAX);
  assign stat.range_ok  = !last_r[IN_W-1] && (first_c <= last_c);
  assign stat.flag_hit  = nonempty_r[idx_r];
  assign stat.idx_last  = (idx_r == WI_W'(WORDS - 1));
  assign stat.idx_at_hi = (idx_r == whi_r);

  // Word read is zero while its flag is clear
  assign rd_eff = rdv_r ? rd_r : '0;

  // Masks for single ID and range
  assign bit_mask = WORD_BITS'(1) << lo_b;
  assign lo_mask  = (idx_r == wlo_r) ? ({WORD_BITS{1'b1}} << lo_b) : '1;
  assign hi_mask  = (idx_r == whi_r) ? ({WORD_BITS{1'b1}} >> (TOP_BIT - hi_b)) : '1;
  assign rng_mask = lo_mask & hi_mask;

  // Lowest set bit of the word read
  always_comb begin
    ffs_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (rd_eff[b]) begin
        ffs_pos = BI_W'(b);
      end
    end
  end

  assign taken_nxt = ID_W'(idx_r * WORD_BITS) + ID_W'(ffs_pos);

  // Updated word per operation
  always_comb begin
    case (op_r)
      OP_ADD:    word_nxt = rd_eff | bit_mask;
      OP_REMOVE: word_nxt = rd_eff & ~bit_mask;
      OP_TAKE:   word_nxt = rd_eff & (rd_eff - WORD_BITS'(1));
      OP_RANGE:  word_nxt = rd_eff | rng_mask;
      default:   word_nxt = rd_eff;
    endcase
  end

  // Request capture and pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      first_r <= in_first_id;
      last_r  <= in_last_id;
    end
    if (cmd.decode) begin
      wlo_r <= q_lo;
      whi_r <= q_hi;
      idx_r <= (op_r == OP_TAKE) ? '0 : q_lo;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Word memory: registered read, write back of modified word
  always_ff @(posedge clk) begin
    rd_r <= mem[idx_r];
    if (cmd.wr_en) begin
      mem[idx_r] <= word_nxt;
    end
  end

  // Occupancy flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '0;
      rdv_r      <= 1'b0;
    end else begin
      rdv_r <= nonempty_r[idx_r];
      if (cmd.clear_all) begin
        nonempty_r <= '0;
      end else if (cmd.wr_en) begin
        nonempty_r[idx_r] <= (word_nxt != '0);
      end
    end
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
    end
    if (cmd.respond) begin
      taken_r <= cmd.resp_take ? taken_nxt : '0;
      empty_r <= cmd.resp_empty;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_taken_id  = taken_r;
  assign out_was_empty = empty_r;

endmodule
